[rtl/pqft_pkg.sv]
`timescale 1ns / 1ps

package pqft_pkg;

  // queue geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int OP_W     = 1;
  localparam int PRIO_W   = 16;
  localparam int TAG_W    = 16;
  localparam int ARR_W    = 32;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_SERVE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // arrival number at which the queue reports full; it is never handed out
  localparam logic [ARR_W-1:0] ARRIVAL_LAST = '1;

  // one stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [ARR_W-1:0]  arrival;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_EMIT
  } state_t;

endpackage

[rtl/pqft_ram.sv]
`timescale 1ns / 1ps

module pqft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/priority_queue_fifo_tiebreak.sv]
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_operation, in_priority_req, in_tag
// out     | output    | out_valid / out_ready | out_status, out_served_tag,
//         |           |                       | out_served_priority
//
// an insert or a rejected item goes from idle straight to emit; a serve on n stored
// entries scans all n of them and then moves the last entry, since the single read port of the entry ram delivers one
// entry per cycle to the shared compare unit and one more read fetches the last entry.
// reset empties the queue and clears the arrival counter; the ram is not cleared,
// the entry count bounds every read. a result waits in the output register and
// the sequencer holds in its last state while that register is still occupied.

module priority_queue_fifo_tiebreak (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pqft_pkg::OP_W-1:0]    in_operation,
  input  logic [pqft_pkg::PRIO_W-1:0]  in_priority_req,
  input  logic [pqft_pkg::TAG_W-1:0]   in_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pqft_pkg::STATUS_W-1:0] out_status,
  output logic [pqft_pkg::TAG_W-1:0]   out_served_tag,
  output logic [pqft_pkg::PRIO_W-1:0]  out_served_priority
);

  import pqft_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ARR_W-1:0]    arrival_r, arrival_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  entry_t              best_r, best_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [PRIO_W-1:0]   res_prio_r, res_prio_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic [PRIO_W-1:0]   out_prio_r, out_prio_nxt;

  logic             in_xfer;
  logic             out_free;
  logic             full;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] last_idx;
  logic             scan_last;
  logic             cand_wins;
  entry_t           rd_entry;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // true when entry a goes out before entry b
  function automatic logic more_urgent(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio > b.prio);
    end else begin
      res = (a.arrival < b.arrival);
    end
    return res;
  endfunction

  // entry storage
  pqft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared decode
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r == CNT_W'(CAPACITY)) || (arrival_r == ARRIVAL_LAST);
  assign count_dec = count_r - CNT_W'(1);
  assign last_idx  = count_dec[IDX_W-1:0];
  assign scan_last = (rd_idx_r == last_idx);
  assign rd_entry  = entry_t'(ram_rdata);
  assign cand_wins = (rd_idx_r == '0) || more_urgent(rd_entry, best_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_operation == OP_SERVE && count_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_nxt      = count_r;
    arrival_nxt    = arrival_r;
    rd_idx_nxt     = rd_idx_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_prio_nxt   = res_prio_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_prio_nxt   = out_prio_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[IDX_W-1:0];
    ram_wdata      = entry_t'{prio: in_priority_req, tag: in_tag, arrival: arrival_r};
    ram_raddr      = '0;

    // output register drains on transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_idx_nxt = '0;
        if (in_xfer) begin
          res_status_nxt = ST_OK;
          res_tag_nxt    = '0;
          res_prio_nxt   = '0;
          if (in_operation == OP_INSERT) begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we      = 1'b1;
              count_nxt   = count_r + CNT_W'(1);
              arrival_nxt = arrival_r + ARR_W'(1);
            end
          end else if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
          end
        end
      end
      S_SCAN: begin
        // compare the entry now on the read port against the best so far
        if (cand_wins) begin
          best_nxt     = rd_entry;
          best_idx_nxt = rd_idx_r;
        end
        if (scan_last) begin
          ram_raddr = last_idx;
        end else begin
          ram_raddr  = rd_idx_r + IDX_W'(1);
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      S_MOVE: begin
        // last entry fills the hole left by the served one
        ram_we       = 1'b1;
        ram_waddr    = best_idx_r;
        ram_wdata    = rd_entry;
        count_nxt    = count_dec;
        res_tag_nxt  = best_r.tag;
        res_prio_nxt = best_r.prio;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_tag_nxt    = res_tag_r;
          out_prio_nxt   = res_prio_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      arrival_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      arrival_r   <= arrival_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_prio_r   <= res_prio_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_served_tag      = out_tag_r;
  assign out_served_priority = out_prio_r;

endmodule

[dv/priority_queue_fifo_tiebreak_test.sv]
`timescale 1ns / 1ps

module priority_queue_fifo_tiebreak_test;
  import pqft_pkg::*;

  localparam int STIM_ITEMS   = 1050;
  localparam int QUIET_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int CYCLE_LIMIT  = 600000;

  // one item waiting to be sent; hold makes the sender wait for an empty pipe
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    bit                hold;
  } queue_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [PRIO_W-1:0]   prio;
  } served_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = OP_INSERT;
  logic [PRIO_W-1:0]   in_priority_req = '0;
  logic [TAG_W-1:0]    in_tag = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_served_tag;
  logic [PRIO_W-1:0]   out_served_priority;

  queue_item_t    item_backlog[$];
  served_result_t due_results[$];
  queue_item_t    live_item;

  // shadow of the queue contents
  entry_t           held_entries[CAPACITY];
  int unsigned      held_count = 0;
  logic [ARR_W-1:0] next_arrival = '0;

  int  plan_count = 0;
  int  stim_total = 0;
  int  accepted_count = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  idle_allowed;

  assign idle_allowed = (accepted_count + QUIET_ITEMS < stim_total);

  priority_queue_fifo_tiebreak i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_priority_req     (in_priority_req),
    .in_tag              (in_tag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_served_tag      (out_served_tag),
    .out_served_priority (out_served_priority)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one accepted item to the shadow queue and queue up its result
  function automatic void predict_queue_result(input queue_item_t it);
    served_result_t res;
    int unsigned    best;
    entry_t         pick;
    res = '0;
    res.status = ST_OK;
    if (it.op == OP_INSERT) begin
      if (held_count >= CAPACITY || next_arrival == ARRIVAL_LAST) begin
        res.status = ST_FULL;
      end else begin
        held_entries[held_count] = '{prio: it.prio, tag: it.tag, arrival: next_arrival};
        held_count++;
        next_arrival++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // highest priority wins, earliest arrival breaks ties
      best = 0;
      for (int unsigned i = 1; i < held_count; i++) begin
        if (held_entries[i].prio > held_entries[best].prio ||
            (held_entries[i].prio == held_entries[best].prio &&
             held_entries[i].arrival < held_entries[best].arrival)) begin
          best = i;
        end
      end
      pick = held_entries[best];
      held_count--;
      held_entries[best] = held_entries[held_count];
      res.tag  = pick.tag;
      res.prio = pick.prio;
    end
    due_results.push_back(res);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_priority(input int unsigned spread);
    case (spread)
      0: begin
        // heavy ties
        return PRIO_W'($urandom_range(0, 3));
      end
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 16'hFFFE;
          default: return PRIO_W'($urandom_range(0, 1));
        endcase
      end
      default: begin
        return PRIO_W'($urandom);
      end
    endcase
  endfunction

  task automatic add_item(input logic [OP_W-1:0] op, input logic [PRIO_W-1:0] p,
                          input logic [TAG_W-1:0] t, input bit hold);
    queue_item_t it;
    it.op   = op;
    it.prio = p;
    it.tag  = t;
    it.hold = hold;
    item_backlog.push_back(it);
    if (op == OP_INSERT) begin
      if (plan_count < CAPACITY) plan_count++;
    end else if (plan_count > 0) begin
      plan_count--;
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    bit          first;
    bit          hold;
    int unsigned segment;
    int unsigned spread;
    int unsigned extra;
    int unsigned burst;
    int unsigned insert_pct;

    // serve on empty with nonzero fields, extremes, ties on both ends
    add_item(OP_SERVE,  '1,       '1,       1'b0);
    add_item(OP_INSERT, '0,       '1,       1'b0);
    add_item(OP_INSERT, '1,       '0,       1'b0);
    add_item(OP_INSERT, 16'h8000, 16'h5A5A, 1'b0);
    add_item(OP_INSERT, '1,       16'h0001, 1'b0);
    add_item(OP_INSERT, '0,       16'h0002, 1'b0);
    add_item(OP_INSERT, 16'h7FFF, 16'hA5A5, 1'b0);
    repeat (7) add_item(OP_SERVE, 16'h1234, 16'h4321, 1'b0);

    // random segments: fill past full then drain past empty, or mixed bursts
    first = 1'b1;
    while (item_backlog.size() < STIM_ITEMS) begin
      segment = first ? 0 : $urandom_range(0, 9);
      hold    = first || ($urandom_range(0, 3) == 0);
      spread  = $urandom_range(0, 2);
      if (segment < 2) begin
        extra = $urandom_range(1, 3);
        while (plan_count < CAPACITY) begin
          add_item(OP_INSERT, pick_priority(spread), TAG_W'($urandom), hold);
          hold = 1'b0;
        end
        repeat (extra) add_item(OP_INSERT, pick_priority(spread), TAG_W'($urandom), 1'b0);
        while (plan_count > 0) begin
          add_item(OP_SERVE, PRIO_W'($urandom), TAG_W'($urandom), 1'b0);
        end
        add_item(OP_SERVE, PRIO_W'($urandom), TAG_W'($urandom), 1'b0);
      end else begin
        burst      = $urandom_range(10, 40);
        insert_pct = $urandom_range(30, 80);
        repeat (burst) begin
          if ($urandom_range(1, 100) <= insert_pct) begin
            add_item(OP_INSERT, pick_priority(spread), TAG_W'($urandom), hold);
          end else begin
            add_item(OP_SERVE, PRIO_W'($urandom), TAG_W'($urandom), hold);
          end
          hold = 1'b0;
        end
      end
      first = 1'b0;
    end
    stim_total = item_backlog.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < stim_total || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_queue_result(live_item);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (item_backlog.size() == 0 ||
                     (item_backlog[0].hold && due_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          live_item = item_backlog.pop_front();
          in_valid        <= 1'b1;
          in_operation    <= live_item.op;
          in_priority_req <= live_item.prio;
          in_tag          <= live_item.tag;
          if (idle_allowed && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 16);
          end
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    served_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with none expected, got status %0d tag %h prio %h",
                   $time, out_status, out_served_tag, out_served_priority);
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            error_count++;
          end
          if (out_served_tag !== want.tag) begin
            $display("%0t: served_tag mismatch, expected %h, actual %h",
                     $time, want.tag, out_served_tag);
            error_count++;
          end
          if (out_served_priority !== want.prio) begin
            $display("%0t: served_priority mismatch, expected %h, actual %h",
                     $time, want.prio, out_served_priority);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule
